FILE: sv/awnf_pkg.sv
package awnf_pkg;

  // Fixed field widths
  localparam int PIX_W     = 24;
  localparam int COORD_W   = 9;
  localparam int CFG_W     = 32;
  localparam int DIM_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;

  // Datapath widths: 32b signed coef x 10b signed column/row, then a three-term sum
  localparam int PROD_W = CFG_W + COORD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // Accept-to-strobe latency of a fetch
  localparam int LATENCY = 5;

  // Defaults for the frame store geometry
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // Opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X_FROM_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X_FROM_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y_FROM_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y_FROM_ROW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd7;

  // Register reset values (identity transform, full 512x512 image)
  localparam logic [CFG_W-1:0] RST_COEF_ONE  = 32'h0001_0000;
  localparam logic [CFG_W-1:0] RST_COEF_ZERO = 32'h0000_0000;
  localparam logic [DIM_W-1:0] RST_DIM       = 10'd512;

  typedef struct packed {
    logic             opcode;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel_in;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] source_column;
    logic [COORD_W-1:0] source_row;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] coef_x_from_col;
    logic [CFG_W-1:0] coef_x_from_row;
    logic [CFG_W-1:0] offset_x;
    logic [CFG_W-1:0] coef_y_from_col;
    logic [CFG_W-1:0] coef_y_from_row;
    logic [CFG_W-1:0] offset_y;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_regs_t;

  // Frame store access issued by the mapping pipeline
  typedef struct packed {
    logic we;
    logic rd;
  } ram_req_t;

endpackage

FILE: sv/awnf_ram.sv
module awnf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/awnf_cfg.sv
module awnf_cfg
  import awnf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_regs_t            regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // Register write decode
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_X_FROM_COL: regs_nxt.coef_x_from_col = cfg_wdata;
        REG_COEF_X_FROM_ROW: regs_nxt.coef_x_from_row = cfg_wdata;
        REG_OFFSET_X:        regs_nxt.offset_x        = cfg_wdata;
        REG_COEF_Y_FROM_COL: regs_nxt.coef_y_from_col = cfg_wdata;
        REG_COEF_Y_FROM_ROW: regs_nxt.coef_y_from_row = cfg_wdata;
        REG_OFFSET_Y:        regs_nxt.offset_y        = cfg_wdata;
        REG_IMAGE_WIDTH:     regs_nxt.image_width     = cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    regs_nxt.image_height    = cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.coef_x_from_col <= RST_COEF_ONE;
      regs_r.coef_x_from_row <= RST_COEF_ZERO;
      regs_r.offset_x        <= RST_COEF_ZERO;
      regs_r.coef_y_from_col <= RST_COEF_ZERO;
      regs_r.coef_y_from_row <= RST_COEF_ONE;
      regs_r.offset_y        <= RST_COEF_ZERO;
      regs_r.image_width     <= RST_DIM;
      regs_r.image_height    <= RST_DIM;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

FILE: sv/awnf_map.sv
module awnf_map
  import awnf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_take,
  input  in_t                                      in_item,
  input  cfg_regs_t                                cfg,
  output ram_req_t                                 req,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]  req_addr,
  output logic [PIX_W-1:0]                         req_wdata,
  output logic [COORD_W-1:0]                       req_col,
  output logic [COORD_W-1:0]                       req_row
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH*MAX_HEIGHT);
  localparam logic [AW-1:0] MW_A = AW'(MAX_WIDTH);

  // Stage 1: products
  logic                      v1_r, op1_r;
  logic [COORD_W-1:0]        col1_r, row1_r;
  logic [PIX_W-1:0]          pix1_r;
  logic signed [PROD_W-1:0]  pxc_r, pxr_r, pyc_r, pyr_r;

  // Stage 2: sums
  logic                      v2_r, op2_r;
  logic [COORD_W-1:0]        col2_r, row2_r;
  logic [PIX_W-1:0]          pix2_r;
  logic signed [SUM_W-1:0]   sum_x_r, sum_y_r;

  // Stage 3: clamped point or load point
  logic                      we3_r, rd3_r;
  logic [XW-1:0]             x3_r;
  logic [YW-1:0]             y3_r;
  logic [PIX_W-1:0]          pix3_r;

  // Stage 4: frame store address
  logic                      we4_r, rd4_r;
  logic [AW-1:0]             addr4_r;
  logic [PIX_W-1:0]          pix4_r;
  logic [COORD_W-1:0]        col4_r, row4_r;

  logic [XW-1:0]             wlim, xc, x3_nxt;
  logic [YW-1:0]             hlim, yc, y3_nxt;
  logic signed [SUM_W-1:0]   top_x, top_y;
  logic                      load_ok;

  // Last valid column and row, from the size registers
  always_comb begin
    if (cfg.image_width == '0) begin
      wlim = '0;
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      wlim = XW'(MAX_WIDTH - 1);
    end else begin
      wlim = XW'(cfg.image_width - 10'd1);
    end
    if (cfg.image_height == '0) begin
      hlim = '0;
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      hlim = YW'(MAX_HEIGHT - 1);
    end else begin
      hlim = YW'(cfg.image_height - 10'd1);
    end
  end

  // Clamp to [0, last] in signed Q28.16 and drop the fraction
  always_comb begin
    top_x = $signed({{(SUM_W-FRAC_W-XW){1'b0}}, wlim, {FRAC_W{1'b0}}});
    top_y = $signed({{(SUM_W-FRAC_W-YW){1'b0}}, hlim, {FRAC_W{1'b0}}});
    if (sum_x_r[SUM_W-1]) begin
      xc = '0;
    end else if (sum_x_r > top_x) begin
      xc = wlim;
    end else begin
      xc = sum_x_r[FRAC_W +: XW];
    end
    if (sum_y_r[SUM_W-1]) begin
      yc = '0;
    end else if (sum_y_r > top_y) begin
      yc = hlim;
    end else begin
      yc = sum_y_r[FRAC_W +: YW];
    end
  end

  // Loads outside the store are dropped
  always_comb begin
    load_ok = (32'(col2_r) < 32'(MAX_WIDTH)) && (32'(row2_r) < 32'(MAX_HEIGHT));
    if (op2_r == OP_FETCH) begin
      x3_nxt = xc;
      y3_nxt = yc;
    end else begin
      x3_nxt = XW'(col2_r);
      y3_nxt = YW'(row2_r);
    end
  end

  // Control: valid bits through the stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      we3_r <= 1'b0;
      rd3_r <= 1'b0;
      we4_r <= 1'b0;
      rd4_r <= 1'b0;
    end else begin
      v1_r  <= in_take;
      v2_r  <= v1_r;
      we3_r <= v2_r && (op2_r == OP_LOAD) && load_ok;
      rd3_r <= v2_r && (op2_r == OP_FETCH);
      we4_r <= we3_r;
      rd4_r <= rd3_r;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    op1_r   <= in_item.opcode;
    col1_r  <= in_item.column;
    row1_r  <= in_item.row;
    pix1_r  <= in_item.pixel_in;
    pxc_r   <= $signed(cfg.coef_x_from_col) * $signed({1'b0, in_item.column});
    pxr_r   <= $signed(cfg.coef_x_from_row) * $signed({1'b0, in_item.row});
    pyc_r   <= $signed(cfg.coef_y_from_col) * $signed({1'b0, in_item.column});
    pyr_r   <= $signed(cfg.coef_y_from_row) * $signed({1'b0, in_item.row});

    op2_r   <= op1_r;
    col2_r  <= col1_r;
    row2_r  <= row1_r;
    pix2_r  <= pix1_r;
    sum_x_r <= SUM_W'(pxc_r) + SUM_W'(pxr_r) + SUM_W'($signed(cfg.offset_x));
    sum_y_r <= SUM_W'(pyc_r) + SUM_W'(pyr_r) + SUM_W'($signed(cfg.offset_y));

    x3_r    <= x3_nxt;
    y3_r    <= y3_nxt;
    pix3_r  <= pix2_r;

    addr4_r <= AW'(y3_r) * MW_A + AW'(x3_r);
    pix4_r  <= pix3_r;
    col4_r  <= COORD_W'(x3_r);
    row4_r  <= COORD_W'(y3_r);
  end

  assign req.we    = we4_r;
  assign req.rd    = rd4_r;
  assign req_addr  = addr4_r;
  assign req_wdata = pix4_r;
  assign req_col   = col4_r;
  assign req_row   = row4_r;

endmodule

FILE: sv/affine_warp_nearest_fetch.sv
// Fetch path: products, sums, clamp, address, registered read with out_valid.
// Throughput: one item per clock, loads and fetches in any mix; busy is high only
// while rst_n is low. Items keep order through one frame store port in stage 4.
// Reset clears the registers to an identity transform over 512x512 and empties
// the pipeline; the frame store is not cleared. Results cannot be stalled.
module affine_warp_nearest_fetch
  import awnf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  cfg_regs_t          cfg;
  ram_req_t           req;
  logic [AW-1:0]      req_addr;
  logic [PIX_W-1:0]   req_wdata;
  logic [PIX_W-1:0]   rdata;
  logic [COORD_W-1:0] req_col, req_row;
  logic               out_valid_r;
  logic [COORD_W-1:0] col_r, row_r;

  assign busy = !rst_n;

  awnf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .regs      (cfg)
  );

  awnf_map #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (start && !busy),
    .in_item   (in_data),
    .cfg       (cfg),
    .req       (req),
    .req_addr  (req_addr),
    .req_wdata (req_wdata),
    .req_col   (req_col),
    .req_row   (req_row)
  );

  awnf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (req.we || req.rd),
    .we    (req.we),
    .addr  (req_addr),
    .wdata (req_wdata),
    .rdata (rdata)
  );

  // Result strobe and coordinates line up with the registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req.rd;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= req_col;
    row_r <= req_row;
  end

  assign out_valid              = out_valid_r;
  assign out_data.pixel_out     = rdata;
  assign out_data.source_column = col_r;
  assign out_data.source_row    = row_r;

endmodule

FILE: sv/awnf_chk.sv
module awnf_chk
  import awnf_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid
);

  // Every accepted fetch gives a result after the fixed latency
  a_fetch_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == OP_FETCH) |-> ##LATENCY out_valid)
    else $error("fetch item gave no result");

  // A load gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.opcode == OP_LOAD) |-> ##LATENCY !out_valid)
    else $error("load item gave a result");

  // No result without a fetch accepted the latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_data.opcode == OP_FETCH, LATENCY))
    else $error("result without a matching fetch item");

  // Reset empties the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

endmodule

bind affine_warp_nearest_fetch awnf_chk u_awnf_chk (.*);
